// ===== hdl/i1284neg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i1284neg_pkg
// Shared types and constants of the IEEE 1284 host mode negotiator.
// ----------------------------------------------------------------------------
package i1284neg_pkg;

  // Default width of the tick timer
  localparam int TimerBitsDef = 16;

  // Configuration register widths and reset values
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [15:0] WaitTimeoutRst = 16'd35000;
  localparam logic [7:0]  SetupRst       = 8'd1;
  localparam logic [15:0] ResetHoldRst   = 16'd5000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WAIT_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETUP        = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_HOLD   = 2'd2;

  // Control register bits: selin, init, autofd, strobe (msb to lsb)
  localparam logic [3:0] CTL_STROBE = 4'b0001;
  localparam logic [3:0] CTL_AUTOFD = 4'b0010;
  localparam logic [3:0] CTL_INIT   = 4'b0100;
  localparam logic [3:0] CTL_SELIN  = 4'b1000;
  localparam logic [3:0] CTL_REST   = CTL_SELIN | CTL_INIT;

  // Mode byte masks
  localparam logic [7:0] ECP_MASK    = 8'h30;
  localparam logic [7:0] MODE_KEEP   = 8'hFB;
  localparam logic [7:0] NIBBLE_MODE = 8'h00;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_NEG   = 2'd1,
    OP_TERM  = 2'd2,
    OP_RESET = 2'd3
  } opcode_e;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_T_ACKLO  = 9'b000000010,
    PH_T_ACKHI  = 9'b000000100,
    PH_R_HOLD   = 9'b000001000,
    PH_N_SETUP  = 9'b000010000,
    PH_N_ACK    = 9'b000100000,
    PH_N_STROBE = 9'b001000000,
    PH_N_ACKHI  = 9'b010000000,
    PH_N_PERR   = 9'b100000000
  } phase_e;

  // Who started a terminate sequence
  typedef enum logic [1:0] {
    CALL_REQ  = 2'd0,
    CALL_NEG  = 2'd1,
    CALL_PEND = 2'd2
  } caller_e;

  // One tick request with sampled status
  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] ext_code;
    logic       stat_ack;
    logic       stat_perr;
    logic       stat_sel;
    logic       stat_fault;
  } req_t;

  // One tick result
  typedef struct packed {
    logic [7:0] data_out;
    logic       ctl_strobe;
    logic       ctl_autofd;
    logic       ctl_init;
    logic       ctl_selin;
    logic       busy_res;
    logic       done_res;
    logic       result_code;
    logic [7:0] mode_now;
    logic       in_compat;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/i1284neg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i1284neg_core
// Negotiation sequencer state, configuration registers and one-tick step.
// ----------------------------------------------------------------------------
module i1284neg_core #(
  parameter int TIMER_BITS = i1284neg_pkg::TimerBitsDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               step_i,
  input  i1284neg_pkg::req_t                req_i,
  input  wire                               cfg_we_i,
  input  wire [i1284neg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [i1284neg_pkg::CfgDataW-1:0]  cfg_data_i,
  output i1284neg_pkg::res_t                res_o
);
  import i1284neg_pkg::*;

  localparam int LimW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam logic [LimW-1:0] TmaxW = LimW'({TIMER_BITS{1'b1}});

  // Saturate a limit to the largest timer value
  function automatic logic [TIMER_BITS-1:0] clamp_lim(input logic [15:0] v);
    logic [LimW-1:0] vw;
    vw = LimW'(v);
    if (vw > TmaxW) vw = TmaxW;
    return vw[TIMER_BITS-1:0];
  endfunction

  logic [15:0] wait_cfg_q, reset_cfg_q;
  logic [7:0]  setup_cfg_q;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [7:0]            mode_q, mode_d;
  logic                  compat_q, compat_d;
  logic [7:0]            req_byte_q, req_byte_d;
  logic [7:0]            data_q, data_d;
  logic [3:0]            ctl_q, ctl_d;
  logic                  err_q, err_d;
  caller_e               caller_q, caller_d;

  logic [TIMER_BITS-1:0] wait_lim, setup_lim, reset_lim;
  logic [TIMER_BITS:0]   timer_nxt;
  logic                  wait_expired;
  logic [TIMER_BITS-1:0] timer_sat;
  logic                  setup_done, reset_done;
  logic                  go_term, go_neg, go_reset, go_fin;
  logic                  fin_code;
  caller_e               term_caller;
  logic                  term_end, term_code;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_cfg_q  <= WaitTimeoutRst;
      setup_cfg_q <= SetupRst;
      reset_cfg_q <= ResetHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAIT_TIMEOUT: wait_cfg_q  <= cfg_data_i;
        CFG_SETUP:        setup_cfg_q <= cfg_data_i[7:0];
        CFG_RESET_HOLD:   reset_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Timer limits and compares
  assign wait_lim     = clamp_lim(wait_cfg_q);
  assign setup_lim    = clamp_lim(16'(setup_cfg_q));
  assign reset_lim    = clamp_lim(reset_cfg_q);
  assign timer_nxt    = {1'b0, timer_q} + (TIMER_BITS+1)'(1);
  assign wait_expired = timer_nxt >= {1'b0, wait_lim};
  assign timer_sat    = (&timer_q) ? timer_q : timer_nxt[TIMER_BITS-1:0];
  assign setup_done   = timer_sat >= setup_lim;
  assign reset_done   = timer_sat >= reset_lim;

  // Step the sequencer by one tick
  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    mode_d     = mode_q;
    compat_d   = compat_q;
    req_byte_d = req_byte_q;
    data_d     = data_q;
    ctl_d      = ctl_q;
    err_d      = err_q;
    caller_d   = caller_q;
    go_term     = 1'b0;
    go_neg      = 1'b0;
    go_reset    = 1'b0;
    go_fin      = 1'b0;
    fin_code    = 1'b0;
    term_caller = CALL_REQ;
    term_end    = 1'b0;
    term_code   = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        unique case (req_i.opcode)
          OP_NEG: begin
            req_byte_d = req_i.ext_code;
            if (!compat_q && (mode_q == req_i.ext_code)) begin
              go_fin = 1'b1;
            end else begin
              err_d = 1'b0;
              if (!compat_q) begin
                go_term     = 1'b1;
                term_caller = CALL_NEG;
              end else begin
                go_neg = 1'b1;
              end
            end
          end
          OP_TERM: begin
            go_term     = 1'b1;
            term_caller = CALL_REQ;
          end
          OP_RESET: begin
            err_d    = 1'b0;
            go_reset = 1'b1;
          end
          OP_TICK: ;
          default: ;
        endcase
      end
      PH_T_ACKLO: begin
        if (!req_i.stat_ack) begin
          timer_d = '0;
          ctl_d   = CTL_AUTOFD | CTL_SELIN | CTL_INIT;
          phase_d = PH_T_ACKHI;
        end else if (wait_expired) begin
          timer_d   = '0;
          term_end  = 1'b1;
          term_code = 1'b1;
        end else begin
          timer_d = timer_nxt[TIMER_BITS-1:0];
        end
      end
      PH_T_ACKHI: begin
        if (req_i.stat_ack) begin
          timer_d  = '0;
          ctl_d    = CTL_REST;
          term_end = 1'b1;
        end else if (wait_expired) begin
          timer_d   = '0;
          term_end  = 1'b1;
          term_code = 1'b1;
        end else begin
          timer_d = timer_nxt[TIMER_BITS-1:0];
        end
      end
      PH_R_HOLD: begin
        timer_d = timer_sat;
        if (reset_done) begin
          timer_d     = '0;
          go_term     = 1'b1;
          term_caller = CALL_PEND;
        end
      end
      PH_N_SETUP: begin
        timer_d = timer_sat;
        if (setup_done) begin
          timer_d = '0;
          ctl_d   = CTL_INIT | CTL_AUTOFD;
          phase_d = PH_N_ACK;
        end
      end
      PH_N_ACK: begin
        if (req_i.stat_perr && req_i.stat_sel && req_i.stat_fault && !req_i.stat_ack) begin
          timer_d = '0;
          ctl_d   = CTL_INIT | CTL_AUTOFD | CTL_STROBE;
          phase_d = PH_N_STROBE;
        end else if (wait_expired) begin
          err_d    = 1'b1;
          go_reset = 1'b1;
        end else begin
          timer_d = timer_nxt[TIMER_BITS-1:0];
        end
      end
      PH_N_STROBE: begin
        timer_d = timer_sat;
        if (setup_done) begin
          timer_d = '0;
          ctl_d   = CTL_INIT;
          phase_d = PH_N_ACKHI;
        end
      end
      PH_N_ACKHI: begin
        if (req_i.stat_ack) begin
          timer_d = '0;
          // nibble mode reports support with select low
          if ((req_byte_q == NIBBLE_MODE) ? req_i.stat_sel : !req_i.stat_sel) begin
            err_d       = 1'b1;
            go_term     = 1'b1;
            term_caller = CALL_PEND;
          end else begin
            mode_d   = req_byte_q & MODE_KEEP;
            compat_d = 1'b0;
            if ((req_byte_q & ECP_MASK) != 8'h00) begin
              ctl_d   = CTL_INIT | CTL_AUTOFD;
              phase_d = PH_N_PERR;
            end else begin
              go_fin = 1'b1;
            end
          end
        end else if (wait_expired) begin
          timer_d     = '0;
          err_d       = 1'b1;
          go_term     = 1'b1;
          term_caller = CALL_PEND;
        end else begin
          timer_d = timer_nxt[TIMER_BITS-1:0];
        end
      end
      PH_N_PERR: begin
        if (req_i.stat_perr) begin
          timer_d = '0;
          go_fin  = 1'b1;
        end else if (wait_expired) begin
          timer_d     = '0;
          err_d       = 1'b1;
          go_term     = 1'b1;
          term_caller = CALL_PEND;
        end else begin
          timer_d = timer_nxt[TIMER_BITS-1:0];
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // Route the end of a terminate back to whoever started it
    if (term_end) begin
      unique case (caller_q)
        CALL_NEG: go_neg = 1'b1;
        CALL_PEND: begin
          go_fin   = 1'b1;
          fin_code = err_q;
        end
        default: begin
          go_fin   = 1'b1;
          fin_code = term_code;
        end
      endcase
    end

    // Launch the next sequence
    if (go_term) begin
      caller_d = term_caller;
      compat_d = 1'b1;
      mode_d   = 8'h00;
      ctl_d    = CTL_REST;
      timer_d  = '0;
      phase_d  = PH_T_ACKLO;
    end
    if (go_neg) begin
      data_d  = req_byte_d;
      timer_d = '0;
      phase_d = PH_N_SETUP;
    end
    if (go_reset) begin
      ctl_d   = CTL_REST;
      timer_d = '0;
      phase_d = PH_R_HOLD;
    end
    if (go_fin) begin
      phase_d = PH_IDLE;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      timer_q    <= '0;
      mode_q     <= 8'h00;
      compat_q   <= 1'b1;
      req_byte_q <= 8'h00;
      data_q     <= 8'h00;
      ctl_q      <= CTL_REST;
      err_q      <= 1'b0;
      caller_q   <= CALL_REQ;
    end else if (step_i) begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      mode_q     <= mode_d;
      compat_q   <= compat_d;
      req_byte_q <= req_byte_d;
      data_q     <= data_d;
      ctl_q      <= ctl_d;
      err_q      <= err_d;
      caller_q   <= caller_d;
    end
  end

  // Result of this tick
  always_comb begin
    res_o.data_out    = data_d;
    res_o.ctl_strobe  = ctl_d[0];
    res_o.ctl_autofd  = ctl_d[1];
    res_o.ctl_init    = ctl_d[2];
    res_o.ctl_selin   = ctl_d[3];
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.done_res    = go_fin;
    res_o.result_code = go_fin & fin_code;
    res_o.mode_now    = mode_d;
    res_o.in_compat   = compat_d;
  end

endmodule
`default_nettype wire

// ===== hdl/ieee1284_mode_negotiator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ieee1284_mode_negotiator_top
// Host-side IEEE 1284 negotiation sequencer with stream request and result.
// ----------------------------------------------------------------------------
// Every request on the slave stream is one timer tick carrying the sampled
// status lines and an optional command (tuser): negotiate, terminate or reset.
// Each request yields exactly one result on the master stream with the data
// byte, the four control bits, busy, done with its ok/io-error code, the
// current mode and the compatibility flag. A request is taken every clock
// cycle while the result register is free or draining. The input register
// holds the request; the combinational step loads the result register.
// Commands that arrive while busy are ignored. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only
// while no request is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ieee1284_mode_negotiator_top #(
  parameter int TIMER_BITS = i1284neg_pkg::TimerBitsDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // request stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: ext_code[7:0], stat_ack, stat_perr, stat_sel, stat_fault, 4'b0
  input  wire [15:0]                        s_axis_tdata,
  // tuser: opcode[1:0]
  input  wire [1:0]                         s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: data_out[7:0], ctl_strobe, ctl_autofd, ctl_init, ctl_selin,
  //        busy_res, done_res, result_code, mode_now[7:0], in_compat
  output logic [23:0]                       m_axis_tdata,
  // configuration
  input  wire                               cfg_we_i,
  input  wire [i1284neg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [i1284neg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i1284neg_pkg::*;

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  res_t out_q;
  res_t res;
  logic adv;

  // Step when a request is held and the result slot is free or draining
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.opcode     <= opcode_e'(s_axis_tuser);
      in_q.ext_code   <= s_axis_tdata[7:0];
      in_q.stat_ack   <= s_axis_tdata[8];
      in_q.stat_perr  <= s_axis_tdata[9];
      in_q.stat_sel   <= s_axis_tdata[10];
      in_q.stat_fault <= s_axis_tdata[11];
    end
  end

  i1284neg_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .req_i     (in_q),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.in_compat, out_q.mode_now, out_q.result_code,
                          out_q.done_res, out_q.busy_res, out_q.ctl_selin,
                          out_q.ctl_init, out_q.ctl_autofd, out_q.ctl_strobe,
                          out_q.data_out};

endmodule
`default_nettype wire
